@@ src/kfd_pkg.sv @@
// Shared types and constants for the keyed FIFO with duplicate reject.
// No dependencies; every other file imports this package.
package kfd_pkg;

	// queue geometry
	localparam int DEPTH = 16;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// field widths
	localparam int DATA_W = 32;
	localparam int STAT_W = 3;
	localparam int OCC_W  = 5;

	// action codes
	localparam logic ACT_ENQ = 1'b0;
	localparam logic ACT_DEQ = 1'b1;

	// result status codes
	typedef enum logic [STAT_W-1:0] {
		ST_ENQ   = 3'd0,
		ST_DUP   = 3'd1,
		ST_DEQ   = 3'd2,
		ST_UNDER = 3'd3,
		ST_FULL  = 3'd4
	} kfd_status_t;

	// control broadcast from the top level to every cell
	typedef struct packed {
		logic             enq;    // load the incoming pair at the fill position
		logic             deq;    // shift every cell one place toward the head
		logic [CNT_W-1:0] count;  // pairs held before this transfer
	} kfd_ctrl_t;

endpackage

@@ src/kfd_if.sv @@
// Valid/ready channel interfaces for the input items and the results.
// Depends on kfd_pkg.
interface kfd_in_if import kfd_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic                     action;
	logic signed [DATA_W-1:0] key;
	logic signed [DATA_W-1:0] payload;

	modport source (output valid, action, key, payload, input ready);
	modport sink   (input valid, action, key, payload, output ready);
endinterface

interface kfd_out_if import kfd_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic [STAT_W-1:0]        status;
	logic signed [DATA_W-1:0] out_key;
	logic signed [DATA_W-1:0] out_payload;
	logic [OCC_W-1:0]         occupancy;
	logic                     is_empty;

	modport source (output valid, status, out_key, out_payload, occupancy, is_empty,
		input ready);
	modport sink   (input valid, status, out_key, out_payload, occupancy, is_empty,
		output ready);
endinterface

@@ src/kfd_cell.sv @@
// One storage cell of the queue: a key/payload pair, a shift path from the
// next younger cell and a key comparator. Depends on kfd_pkg.
module kfd_cell import kfd_pkg::*; (
	input  logic                     clk,
	input  kfd_ctrl_t                ctrl,
	input  logic [CNT_W-1:0]         pos,
	input  logic signed [DATA_W-1:0] in_key,
	input  logic signed [DATA_W-1:0] in_payload,
	input  logic signed [DATA_W-1:0] nbr_key,
	input  logic signed [DATA_W-1:0] nbr_payload,
	output logic signed [DATA_W-1:0] key_q,
	output logic signed [DATA_W-1:0] payload_q,
	output logic                     hit
);

	logic held;

	// cell holds a queued pair when it sits below the fill count
	assign held = (pos < ctrl.count);
	assign hit  = held && (key_q == in_key);

	// shift toward the head on dequeue, load at the fill position on enqueue
	always_ff @(posedge clk) begin
		if (ctrl.deq) begin
			key_q     <= nbr_key;
			payload_q <= nbr_payload;
		end else if (ctrl.enq && (pos == ctrl.count)) begin
			key_q     <= in_key;
			payload_q <= in_payload;
		end
	end

endmodule

@@ src/keyed_fifo_with_duplicate_reject.sv @@
// Top level of the keyed FIFO with duplicate reject: fill count, status
// decode, the row of cells and the result register.
// Depends on kfd_pkg, kfd_if and kfd_cell.
//
//  channel  dir  signals                                             transfer
//  in_ch    in   valid ready action key payload                      valid && ready
//  out_ch   out  valid ready status out_key out_payload occupancy    valid && ready
//                is_empty
//
// The duplicate search is one comparator per cell, ORed over the row, and the
// queue state updates at the input transfer.
// The result is registered; a new item is taken while the result register is
// empty or being drained in the same cycle, so a stalled output stalls input.
// Reset clears the fill count and the result valid; cell contents are unset.
module keyed_fifo_with_duplicate_reject import kfd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	kfd_in_if.sink     in_ch,
	kfd_out_if.source  out_ch
);

	logic [CNT_W-1:0]         count_q;
	logic                     out_valid_q;
	kfd_status_t              status_q;
	logic signed [DATA_W-1:0] out_key_q;
	logic signed [DATA_W-1:0] out_payload_q;
	logic [CNT_W-1:0]         occ_q;

	logic                     fire;
	logic                     full;
	logic                     empty;
	logic                     dup;
	kfd_ctrl_t                ctrl;
	kfd_status_t              status_d;
	logic [CNT_W-1:0]         count_d;

	logic signed [DATA_W-1:0] cell_key [DEPTH];
	logic signed [DATA_W-1:0] cell_pay [DEPTH];
	logic [DEPTH-1:0]         cell_hit;

	// handshake
	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign fire        = in_ch.valid && in_ch.ready;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign dup   = |cell_hit;

	// status decode and next count; fullness wins over the duplicate test
	always_comb begin
		status_d = ST_UNDER;
		count_d  = count_q;
		ctrl.enq = 1'b0;
		ctrl.deq = 1'b0;
		ctrl.count = count_q;
		if (in_ch.action == ACT_ENQ) begin
			if (full) begin
				status_d = ST_FULL;
			end else if (dup) begin
				status_d = ST_DUP;
			end else begin
				status_d = ST_ENQ;
				ctrl.enq = fire;
				count_d  = count_q + CNT_W'(1);
			end
		end else begin
			if (empty) begin
				status_d = ST_UNDER;
			end else begin
				status_d = ST_DEQ;
				ctrl.deq = fire;
				count_d  = count_q - CNT_W'(1);
			end
		end
	end

	// row of cells, cell 0 holds the oldest pair
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [DATA_W-1:0] nbr_key;
		logic signed [DATA_W-1:0] nbr_pay;

		if (i == DEPTH - 1) begin : g_last
			assign nbr_key = '0;
			assign nbr_pay = '0;
		end else begin : g_mid
			assign nbr_key = cell_key[i+1];
			assign nbr_pay = cell_pay[i+1];
		end

		kfd_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.pos         (CNT_W'(i)),
			.in_key      (in_ch.key),
			.in_payload  (in_ch.payload),
			.nbr_key     (nbr_key),
			.nbr_payload (nbr_pay),
			.key_q       (cell_key[i]),
			.payload_q   (cell_pay[i]),
			.hit         (cell_hit[i])
		);
	end

	// fill count and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (fire) begin
			status_q      <= status_d;
			occ_q         <= count_d;
			out_key_q     <= (status_d == ST_DEQ) ? cell_key[0] : '0;
			out_payload_q <= (status_d == ST_DEQ) ? cell_pay[0] : '0;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.status      = status_q;
	assign out_ch.out_key     = out_key_q;
	assign out_ch.out_payload = out_payload_q;
	assign out_ch.occupancy   = OCC_W'(occ_q);
	assign out_ch.is_empty    = (occ_q == '0);

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("fill count above depth");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid_q)
		else $error("accepted item produced no result");

	a_enq_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.enq |=> (status_q == ST_ENQ) && (count_q == $past(count_q) + CNT_W'(1)))
		else $error("enqueue did not advance the count");

	a_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (in_ch.action == ACT_DEQ) && empty |=>
		(status_q == ST_UNDER) && (count_q == '0) && (out_key_q == '0))
		else $error("bad underflow result");

endmodule

@@ verif/keyed_fifo_with_duplicate_reject_test.sv @@
// Self-checking testbench for keyed_fifo_with_duplicate_reject: directed and random
// enqueue/dequeue traffic with random idles on both channels, checked against a shadow queue.
// Depends on kfd_pkg, kfd_if and the RTL of the block.
`timescale 1ns / 1ps

module keyed_fifo_with_duplicate_reject_test;
	import kfd_pkg::*;

	localparam int RAND_ITEMS  = 1600;
	localparam int KEY_POOL    = 24;
	localparam int CYCLE_LIMIT = 200000;
	localparam int MAX_PRINTS  = 50;

	typedef struct {
		logic                     action;
		logic signed [DATA_W-1:0] key;
		logic signed [DATA_W-1:0] payload;
	} fifo_req_t;

	typedef struct {
		kfd_status_t              status;
		logic signed [DATA_W-1:0] key;
		logic signed [DATA_W-1:0] payload;
		logic [OCC_W-1:0]         occupancy;
		logic                     is_empty;
	} fifo_resp_t;

	logic clk;
	logic arst_n;

	kfd_in_if  in_ch ();
	kfd_out_if out_ch ();

	keyed_fifo_with_duplicate_reject dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	fifo_req_t  pending_reqs[$];
	fifo_resp_t awaited_results[$];
	int         mismatches;
	int         taken;
	int         cycles;

	// shadow copy of the queue contents
	logic signed [DATA_W-1:0] shadow_key[DEPTH];
	logic signed [DATA_W-1:0] shadow_payload[DEPTH];
	int                       shadow_head;
	int                       shadow_tail;
	int                       shadow_count;

	// no idles on either side in this window of transfers
	wire quiet = (taken >= 500) && (taken < 800);

	// apply one request to the shadow queue and return the result it must produce
	function automatic fifo_resp_t apply_to_shadow(fifo_req_t req);
		fifo_resp_t r;
		bit         held;
		int         slot;
		r.key     = '0;
		r.payload = '0;
		if (req.action == ACT_ENQ) begin
			held = 1'b0;
			slot = shadow_head;
			for (int n = 0; n < shadow_count; n++) begin
				if (shadow_key[slot] == req.key)
					held = 1'b1;
				slot = (slot + 1) % DEPTH;
			end
			if (shadow_count >= DEPTH) begin
				// fullness wins over the duplicate search
				r.status = ST_FULL;
			end else if (held) begin
				r.status = ST_DUP;
			end else begin
				shadow_key[shadow_tail]     = req.key;
				shadow_payload[shadow_tail] = req.payload;
				shadow_tail                 = (shadow_tail + 1) % DEPTH;
				shadow_count++;
				r.status = ST_ENQ;
			end
		end else begin
			if (shadow_count == 0) begin
				r.status = ST_UNDER;
			end else begin
				r.key       = shadow_key[shadow_head];
				r.payload   = shadow_payload[shadow_head];
				shadow_head = (shadow_head + 1) % DEPTH;
				shadow_count--;
				r.status = ST_DEQ;
			end
		end
		r.occupancy = shadow_count[OCC_W-1:0];
		r.is_empty  = (shadow_count == 0);
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
		mismatches++;
		if (mismatches <= MAX_PRINTS)
			$display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
	endtask

	task automatic add_req(logic action, logic [DATA_W-1:0] key, logic [DATA_W-1:0] payload);
		fifo_req_t req;
		req.action  = action;
		req.key     = key;
		req.payload = payload;
		pending_reqs.push_back(req);
	endtask

	// clock and reset
	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		in_ch.valid    = 1'b0;
		in_ch.action   = ACT_ENQ;
		in_ch.key      = '0;
		in_ch.payload  = '0;
		out_ch.ready   = 1'b0;
		fork
			forever #5 clk = ~clk;
			begin
				repeat (12) @(posedge clk);
				@(negedge clk) arst_n = 1'b1;
			end
		join_none
	end

	// input driver: on a transfer, predict the result; then present the next item
	always @(posedge clk) begin : drive_in
		fifo_req_t cur;
		fifo_req_t nxt;
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) begin
				cur.action  = in_ch.action;
				cur.key     = in_ch.key;
				cur.payload = in_ch.payload;
				awaited_results.push_back(apply_to_shadow(cur));
				taken++;
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (pending_reqs.size() != 0 && (quiet || $urandom_range(0, 99) >= 15)) begin
					nxt = pending_reqs.pop_front();
					in_ch.valid   <= 1'b1;
					in_ch.action  <= nxt.action;
					in_ch.key     <= nxt.key;
					in_ch.payload <= nxt.payload;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor with random back-pressure
	always @(posedge clk) begin : watch_out
		fifo_resp_t want;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				if (awaited_results.size() == 0) begin
					report_mismatch("unexpected result", DATA_W'(out_ch.status), '0);
				end else begin
					want = awaited_results.pop_front();
					if (out_ch.status !== want.status)
						report_mismatch("status", DATA_W'(out_ch.status),
							DATA_W'(want.status));
					if (out_ch.out_key !== want.key)
						report_mismatch("out_key", out_ch.out_key, want.key);
					if (out_ch.out_payload !== want.payload)
						report_mismatch("out_payload", out_ch.out_payload, want.payload);
					if (out_ch.occupancy !== want.occupancy)
						report_mismatch("occupancy", DATA_W'(out_ch.occupancy),
							DATA_W'(want.occupancy));
					if (out_ch.is_empty !== want.is_empty)
						report_mismatch("is_empty", DATA_W'(out_ch.is_empty),
							DATA_W'(want.is_empty));
				end
			end
			out_ch.ready <= quiet || ($urandom_range(0, 99) >= 15);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// stimulus and end of run
	initial begin : stimulus
		logic [DATA_W-1:0] pool[KEY_POOL];
		int                made;
		int                span;
		int                deq_pct;
		int                roll;
		logic [DATA_W-1:0] k;
		bit                filling;

		mismatches   = 0;
		taken        = 0;
		cycles       = 0;
		shadow_head  = 0;
		shadow_tail  = 0;
		shadow_count = 0;

		// underflow from reset, extreme keys and payloads
		add_req(ACT_DEQ, 32'h1234_5678, 32'h9abc_def0);
		add_req(ACT_ENQ, 32'h8000_0000, 32'h7fff_ffff);
		add_req(ACT_ENQ, 32'h7fff_ffff, 32'h8000_0000);
		add_req(ACT_ENQ, 32'h0000_0000, 32'h0000_0000);
		add_req(ACT_ENQ, 32'hffff_ffff, 32'hffff_ffff);
		// duplicate, then the key that left the head accepted again once it has left
		add_req(ACT_ENQ, 32'h0000_0000, 32'h5555_5555);
		add_req(ACT_DEQ, 32'h0000_0000, 32'h0000_0000);
		add_req(ACT_ENQ, 32'h8000_0000, 32'haaaa_aaaa);
		// fill to the brim, then full with a held key and with a new one
		for (int i = 1; i <= DEPTH - 4; i++)
			add_req(ACT_ENQ, 32'h1000_0000 + i, $urandom);
		add_req(ACT_ENQ, 32'h0000_0000, 32'h1111_1111);
		add_req(ACT_ENQ, 32'h7654_3210, 32'h2222_2222);

		// random part: alternating fill and drain phases over a small key pool
		foreach (pool[i])
			pool[i] = $urandom;
		made    = 0;
		filling = 1'b0;
		while (made < RAND_ITEMS) begin
			span    = $urandom_range(10, 60);
			deq_pct = filling ? 25 : 75;
			filling = !filling;
			pool[$urandom_range(0, KEY_POOL - 1)] = $urandom;
			for (int i = 0; i < span && made < RAND_ITEMS; i++) begin
				roll = $urandom_range(0, 99);
				k    = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, KEY_POOL - 1)]
					: $urandom;
				add_req((roll < deq_pct) ? ACT_DEQ : ACT_ENQ, k, $urandom);
				made++;
			end
		end

		while (!arst_n || pending_reqs.size() != 0 || in_ch.valid
			|| awaited_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (mismatches == 0 && awaited_results.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
